### sv/key_prefix_block_encoder_macros.svh
// assertion macros for the key prefix block encoder checker
// expects clk and rst in the scope of use
`ifndef KEY_PREFIX_BLOCK_ENCODER_MACROS_SVH
`define KEY_PREFIX_BLOCK_ENCODER_MACROS_SVH

// same-cycle implication
`define KPBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpbe check failed");

// next-cycle implication
`define KPBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpbe check failed");

`endif

### sv/kpbe_pkg.sv
// kpbe_pkg: beat types, mode codes, sequencer states and remainder unit structs
// no dependencies
package kpbe_pkg;

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_VALUE = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  localparam logic [7:0] INTERVAL_RESET = 8'd16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [31:0] value_length;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        entry_start;
    logic        restart;
    logic [31:0] entry_offset;
    logic        overflow;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SHARED,
    ST_UNSHARED,
    ST_VARINT,
    ST_KEY
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

### sv/kpbe_key_mem.sv
// kpbe_key_mem: two key banks (previous and current key), one write port,
// two registered read ports; uses no package
module kpbe_key_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          a_bank,
  input  logic [AW-1:0] a_addr,
  output logic [7:0]    a_data,
  input  logic          b_bank,
  input  logic [AW-1:0] b_addr,
  output logic [7:0]    b_data
);

  logic [7:0] store [2][DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_bank][wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    a_data <= store[a_bank][a_addr];
    b_data <= store[b_bank][b_addr];
  end

endmodule

### sv/kpbe_rem_unit.sv
// kpbe_rem_unit: restoring remainder of an 8-bit dividend, one bit a cycle
// through one shared subtract and compare; uses kpbe_pkg
module kpbe_rem_unit
  import kpbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic       busy;
  logic [2:0] step;
  logic [7:0] dvd;
  logic [7:0] dsr;
  logic [7:0] rem;
  logic       done;
  logic [8:0] trial;
  logic [8:0] diff;

  assign trial = {rem, dvd[7]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[6:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff[7:0];
      end else begin
        rem <= trial[7:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.zero = (rem == 8'd0);

endmodule

### sv/key_prefix_block_encoder.sv
// value byte: accepted when the output register is free, beat valid the next cycle
// key byte: one a cycle when idle, no beat; last key byte: remainder unit restart
// check, then one beat a cycle unless res_stall (3 to 39), input stalled until done
// synchronous reset clears the block state and sets the interval to 16;
// key bank contents are left as they are
module key_prefix_block_encoder
  import kpbe_pkg::*;
#(
  parameter int MAX_KEY = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_stall,
  output res_t       res,
  output logic       res_valid,
  input  logic       res_stall
);

  localparam int LW = $clog2(MAX_KEY + 1);
  localparam int AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam logic [LW-1:0] KEY_MAX = LW'(MAX_KEY);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  state_t state, state_next;

  logic [7:0]    intv;
  logic [LW-1:0] prev_len;
  logic [LW-1:0] prev_shared;
  logic [7:0]    rcnt;
  logic [LW-1:0] cur_len, cur_len_next;
  logic [LW-1:0] rp;
  logic          broken;
  logic [31:0]   boff;
  logic          kovf;
  logic          sel, sel_next;
  logic [LW-1:0] idx, idx_next;

  logic          rs;
  logic [LW-1:0] shared;
  logic [LW-1:0] unshared;
  logic [31:0]   eoff;
  logic [31:0]   vrem;

  logic          acc;
  logic          out_free;
  logic          take_key;
  logic          key_store;
  logic          match;
  logic          rs_calc;
  logic [LW-1:0] shared_calc;
  logic          more;
  logic          load;
  logic          fin;
  res_t          beat;

  logic [7:0]    rd_a;
  logic [7:0]    rd_b;
  rem_req_t      rreq;
  rem_rsp_t      rrsp;

  assign out_free   = !(res_valid && res_stall);
  assign item_stall = (state != ST_IDLE) || (!out_free && item.mode == MODE_VALUE);
  assign acc        = item_valid && !item_stall;
  assign take_key   = acc && item.mode == MODE_KEY;
  assign key_store  = take_key && (cur_len < KEY_MAX);
  assign match      = !broken && (cur_len < prev_len) && (rd_a == item.data_byte);
  assign more       = |vrem[31:7];

  assign rs_calc     = (intv == 8'd0) || rrsp.zero || (rp == '0) || (rp < prev_shared);
  assign shared_calc = rs_calc ? '0 : rp;

  assign rreq.start    = take_key && item.last;
  assign rreq.dividend = rcnt;
  assign rreq.divisor  = intv;

  kpbe_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rreq),
    .rsp (rrsp)
  );

  kpbe_key_mem #(
    .DEPTH (MAX_KEY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (key_store),
    .wr_bank (~sel),
    .wr_addr (cur_len[AW-1:0]),
    .wr_data (item.data_byte),
    .a_bank  (sel_next),
    .a_addr  (cur_len_next[AW-1:0]),
    .a_data  (rd_a),
    .b_bank  (~sel),
    .b_addr  (idx_next[AW-1:0]),
    .b_data  (rd_b)
  );

  always_comb begin
    state_next        = state;
    load              = 1'b0;
    fin               = 1'b0;
    beat.out_byte     = 8'd0;
    beat.run_last     = 1'b0;
    beat.entry_start  = 1'b0;
    beat.restart      = rs;
    beat.entry_offset = eoff;
    beat.overflow     = kovf;
    idx_next          = idx;
    unique case (state)
      ST_IDLE: begin
        if (acc && item.mode == MODE_VALUE) begin
          load              = 1'b1;
          beat.out_byte     = item.data_byte;
          beat.run_last     = 1'b1;
          beat.restart      = 1'b0;
          beat.entry_offset = 32'd0;
          beat.overflow     = 1'b0;
        end
        if (take_key && item.last) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (rrsp.done) begin
          idx_next   = shared_calc;
          state_next = ST_SHARED;
        end
      end
      ST_SHARED: begin
        if (out_free) begin
          load             = 1'b1;
          beat.out_byte    = 8'(shared);
          beat.entry_start = 1'b1;
          state_next       = ST_UNSHARED;
        end
      end
      ST_UNSHARED: begin
        if (out_free) begin
          load          = 1'b1;
          beat.out_byte = 8'(unshared);
          state_next    = ST_VARINT;
        end
      end
      ST_VARINT: begin
        if (out_free) begin
          load          = 1'b1;
          beat.out_byte = {more, vrem[6:0]};
          if (!more) begin
            if (idx == cur_len) begin
              beat.run_last = 1'b1;
              fin           = 1'b1;
              state_next    = ST_IDLE;
            end else begin
              state_next = ST_KEY;
            end
          end
        end
      end
      ST_KEY: begin
        if (out_free) begin
          load          = 1'b1;
          beat.out_byte = rd_b;
          idx_next      = idx + LEN_ONE;
          if (idx + LEN_ONE == cur_len) begin
            beat.run_last = 1'b1;
            fin           = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_len_next = cur_len;
    sel_next     = sel;
    if (fin) begin
      cur_len_next = '0;
      sel_next     = ~sel;
    end
    if (acc && item.mode == MODE_BLOCK) begin
      cur_len_next = '0;
    end
    if (key_store) begin
      cur_len_next = cur_len + LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      res_valid   <= 1'b0;
      intv        <= INTERVAL_RESET;
      prev_len    <= '0;
      prev_shared <= '0;
      rcnt        <= '0;
      cur_len     <= '0;
      rp          <= '0;
      broken      <= 1'b0;
      boff        <= '0;
      kovf        <= 1'b0;
      sel         <= 1'b0;
      idx         <= '0;
    end else begin
      state   <= state_next;
      cur_len <= cur_len_next;
      sel     <= sel_next;
      idx     <= idx_next;
      if (cfg_wr_en) begin
        intv <= cfg_wr_data;
      end
      if (load) begin
        res_valid <= 1'b1;
        boff      <= boff + 32'd1;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
      if (acc && item.mode == MODE_BLOCK) begin
        prev_len    <= '0;
        prev_shared <= '0;
        rcnt        <= '0;
        boff        <= '0;
        rp          <= '0;
        broken      <= 1'b0;
        kovf        <= 1'b0;
      end
      if (take_key) begin
        if (cur_len >= KEY_MAX) begin
          kovf <= 1'b1;
        end else if (match) begin
          rp <= rp + LEN_ONE;
        end else begin
          broken <= 1'b1;
        end
      end
      if (fin) begin
        rcnt        <= rs ? 8'd1 : rcnt + 8'd1;
        prev_shared <= shared;
        prev_len    <= cur_len;
        rp          <= '0;
        broken      <= 1'b0;
        kovf        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= beat;
    end
    if (take_key && item.last) begin
      vrem <= item.value_length;
    end else if (state == ST_VARINT && out_free) begin
      vrem <= {7'd0, vrem[31:7]};
    end
    if (state == ST_CALC && rrsp.done) begin
      rs       <= rs_calc;
      shared   <= shared_calc;
      unshared <= cur_len - shared_calc;
      eoff     <= boff;
    end
  end

endmodule

### sv/kpbe_checker.sv
// kpbe_checker: port-level checks on the key prefix block encoder, with its bind
// uses kpbe_pkg and key_prefix_block_encoder_macros.svh
`include "key_prefix_block_encoder_macros.svh"

module kpbe_checker
  import kpbe_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input item_t item,
  input logic  item_valid,
  input logic  item_stall,
  input res_t  res,
  input logic  res_valid,
  input logic  res_stall
);

  // a held beat stays put
  `KPBE_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(res))

  // a value byte comes straight out as a single beat
  `KPBE_ASSERT_NEXT(a_value_pass,
    item_valid && !item_stall && item.mode == MODE_VALUE,
    res_valid && res.run_last && !res.entry_start &&
    res.out_byte == $past(item.data_byte))

  // an entry header is never a single beat
  `KPBE_ASSERT_IMPL(a_header_len, res_valid && res.entry_start, !res.run_last)

  // the last key byte makes the block busy
  `KPBE_ASSERT_NEXT(a_busy_after_key,
    item_valid && !item_stall && item.mode == MODE_KEY && item.last, item_stall)

endmodule

bind key_prefix_block_encoder kpbe_checker u_kpbe_checker (.*);
